### src/bpp_pkg.sv
// Package for the Boris particle pusher: payload structs, register indexes,
// fixed-point limits. No dependencies.
package bpp_pkg;

	typedef struct packed {
		logic        operation;
		logic [31:0] time_step;
		logic signed [47:0] load_pos_x;
		logic signed [47:0] load_pos_y;
		logic signed [47:0] load_pos_z;
		logic signed [47:0] load_vel_x;
		logic signed [47:0] load_vel_y;
		logic signed [47:0] load_vel_z;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] new_pos_x;
		logic signed [47:0] new_pos_y;
		logic signed [47:0] new_pos_z;
		logic signed [47:0] new_vel_x;
		logic signed [47:0] new_vel_y;
		logic signed [47:0] new_vel_z;
	} out_item_t;

	typedef enum logic [2:0] {
		REG_FIELD_X = 3'd0,
		REG_FIELD_Y = 3'd1,
		REG_FIELD_Z = 3'd2,
		REG_CHARGE_MASS = 3'd3,
		REG_TIME_SCALE = 3'd4,
		REG_PAUSED = 3'd5
	} reg_idx_t;

	localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

	function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
			input logic signed [47:0] b, input logic sub);
		logic signed [48:0] s;
		begin
			s = sub ? ({a[47], a} - {b[47], b}) : ({a[47], a} + {b[47], b});
			if (s > 49'sd140737488355327) sat_add = MAX48;
			else if (s < -49'sd140737488355328) sat_add = MIN48;
			else sat_add = s[47:0];
		end
	endfunction

endpackage

### src/bpp_mul.sv
// Sequential multiply-shift-saturate unit: 64x64 magnitude product built from
// four 32x32 partial products accumulated in turn. No dependencies.
module bpp_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	input  logic [5:0]         sh,
	output logic               done,
	output logic signed [47:0] res
);
	logic [63:0]  ua_q, ub_q;
	logic         neg_q;
	logic [5:0]   sh_q;
	logic [127:0] acc_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] ppx, shd;
	logic [47:0]  lim;

	always_comb begin
		pa = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
		pb = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
		pp = {32'd0, pa} * {32'd0, pb};
		ppx = {64'd0, pp} << ({5'd0, cnt_q[0]} + {5'd0, cnt_q[1]}) * 32;
		shd = acc_q >> sh_q;
		lim = neg_q ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (busy_q) begin
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q <= a[63] ? 64'd0 - a : a;
			ub_q <= b[63] ? 64'd0 - b : b;
			neg_q <= a[63] ^ b[63];
			sh_q <= sh;
			acc_q <= '0;
		end else if (busy_q && cnt_q != 3'd4) begin
			acc_q <= acc_q + ppx;
		end else if (busy_q) begin
			if (shd[127:48] != 80'd0 || shd[47:0] > lim) res <= neg_q ? 48'd0 - lim : lim;
			else res <= neg_q ? 48'd0 - shd[47:0] : shd[47:0];
		end
	end
endmodule

### src/bpp_div.sv
// Restoring divider, one quotient bit a cycle, computing 2^49 / den.
// No dependencies.
module bpp_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [48:0] den,
	output logic        done,
	output logic [49:0] quo
);
	logic [49:0] rem_q;
	logic [48:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [50:0] trial;

	assign trial = {rem_q, (cnt_q == 6'd49)} - {2'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= 6'd0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd49;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo <= '0;
		end else if (busy_q) begin
			if (!trial[50]) begin
				rem_q <= trial[49:0];
				quo <= {quo[48:0], 1'b1};
			end else begin
				rem_q <= {rem_q[48:0], (cnt_q == 6'd49)};
				quo <= {quo[48:0], 1'b0};
			end
		end
	end
endmodule

### src/boris_particle_pusher.sv
// Top level of the Boris particle pusher: registers, state, sequencer.
// Depends on bpp_pkg, bpp_mul and bpp_div.
//
// channel  direction  handshake       payload
// in       input      valid / stall   bpp_pkg::in_item_t
// out      output     valid / stall   bpp_pkg::out_item_t
// cfg      input      valid / ready   index, data
//
// A load writes position and velocity when it is accepted. A step runs a setup
// state, 25 multiplies on the shared multiplier and a division in the divider.
// Reset clears state to zero and registers to their defaults. A result waits in
// the output register while the next item is taken; the last multiply of a step
// does not start until that register is free.
module boris_particle_pusher (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bpp_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bpp_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DWT  = 5'b10000
	} state_t;

	state_t state_q;
	logic signed [31:0] bx_q, by_q, bz_q, qm_q;
	logic [31:0] ts_q;
	logic paused_q;
	logic signed [47:0] pos_q [3];
	logic signed [47:0] vel_q [3];
	logic signed [47:0] t_q [3];
	logic signed [47:0] s_q [3];
	logic signed [47:0] vp_q [3];
	logic signed [47:0] vn_q [3];
	logic signed [47:0] h_q, t2_q, acc_q;
	logic [47:0] dt_q;
	logic [49:0] f_q;
	logic [5:0] op_q;
	logic [31:0] tstep_q;
	logic mstart, mdone, dstart, ddone;
	logic signed [63:0] ma, mb;
	logic [5:0] msh;
	logic signed [47:0] mres;
	logic [49:0] quo;
	logic [63:0] dtprod;

	localparam logic [5:0] OP_LAST = 6'd31;

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign dtprod = {32'd0, tstep_q} * {32'd0, ts_q};

	function automatic logic signed [63:0] sx(input logic signed [47:0] v);
		sx = {{16{v[47]}}, v};
	endfunction

	// Operand select for each op of the sequence.
	always_comb begin
		ma = '0; mb = '0; msh = 6'd24;
		case (op_q)
			6'd0: begin ma = {{32{qm_q[31]}}, qm_q}; mb = {16'd0, dt_q}; msh = 6'd17; end
			6'd1: begin ma = {{32{bx_q[31]}}, bx_q}; mb = sx(h_q); msh = 6'd16; end
			6'd2: begin ma = {{32{by_q[31]}}, by_q}; mb = sx(h_q); msh = 6'd16; end
			6'd3: begin ma = {{32{bz_q[31]}}, bz_q}; mb = sx(h_q); msh = 6'd16; end
			6'd4: begin ma = sx(t_q[0]); mb = sx(t_q[0]); end
			6'd5: begin ma = sx(t_q[1]); mb = sx(t_q[1]); end
			6'd6: begin ma = sx(t_q[2]); mb = sx(t_q[2]); end
			6'd7:  begin ma = sx(vel_q[1]); mb = sx(t_q[2]); end
			6'd8:  begin ma = sx(vel_q[2]); mb = sx(t_q[1]); end
			6'd9:  begin ma = sx(vel_q[2]); mb = sx(t_q[0]); end
			6'd10: begin ma = sx(vel_q[0]); mb = sx(t_q[2]); end
			6'd11: begin ma = sx(vel_q[0]); mb = sx(t_q[1]); end
			6'd12: begin ma = sx(vel_q[1]); mb = sx(t_q[0]); end
			6'd13: begin ma = sx(t_q[0]); mb = {14'd0, f_q}; end
			6'd14: begin ma = sx(t_q[1]); mb = {14'd0, f_q}; end
			6'd15: begin ma = sx(t_q[2]); mb = {14'd0, f_q}; end
			6'd16: begin ma = sx(vp_q[1]); mb = sx(s_q[2]); end
			6'd17: begin ma = sx(vp_q[2]); mb = sx(s_q[1]); end
			6'd18: begin ma = sx(vp_q[2]); mb = sx(s_q[0]); end
			6'd19: begin ma = sx(vp_q[0]); mb = sx(s_q[2]); end
			6'd20: begin ma = sx(vp_q[0]); mb = sx(s_q[1]); end
			6'd21: begin ma = sx(vp_q[1]); mb = sx(s_q[0]); end
			6'd22: begin ma = sx(vel_q[0]) + sx(vn_q[0]); mb = {16'd0, dt_q}; msh = 6'd25; end
			6'd23: begin ma = sx(vel_q[1]) + sx(vn_q[1]); mb = {16'd0, dt_q}; msh = 6'd25; end
			6'd24: begin ma = sx(vel_q[2]) + sx(vn_q[2]); mb = {16'd0, dt_q}; msh = 6'd25; end
			default: begin ma = '0; mb = '0; msh = 6'd24; end
		endcase
	end

	bpp_mul u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .sh(msh),
		.done(mdone), .res(mres));
	bpp_div u_div (.clk, .arst_n, .start(dstart), .den({1'b0, 48'd16777216} + {1'b0, t2_q}),
		.done(ddone), .quo(quo));

	assign mstart = (state_q == ST_MUL) && (op_q != 6'd24 || !out_valid);
	assign dstart = (state_q == ST_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			bx_q <= '0; by_q <= '0; bz_q <= '0;
			qm_q <= 32'sd65536;
			ts_q <= 32'd16777216;
			paused_q <= 1'b0;
			op_q <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bpp_pkg::REG_FIELD_X:     bx_q <= cfg_data;
					bpp_pkg::REG_FIELD_Y:     by_q <= cfg_data;
					bpp_pkg::REG_FIELD_Z:     bz_q <= cfg_data;
					bpp_pkg::REG_CHARGE_MASS: qm_q <= cfg_data;
					bpp_pkg::REG_TIME_SCALE:  ts_q <= cfg_data;
					bpp_pkg::REG_PAUSED:      paused_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						if (in_data.operation) begin
							pos_q[0] <= in_data.load_pos_x;
							pos_q[1] <= in_data.load_pos_y;
							pos_q[2] <= in_data.load_pos_z;
							vel_q[0] <= in_data.load_vel_x;
							vel_q[1] <= in_data.load_vel_y;
							vel_q[2] <= in_data.load_vel_z;
						end else if (!paused_q) begin
							tstep_q <= in_data.time_step;
							op_q <= OP_LAST;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_MUL: begin
					if (mstart) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (op_q == OP_LAST) begin
						dt_q <= dtprod[63:16];
						op_q <= 6'd0;
						state_q <= ST_MUL;
					end else if (mdone) begin
						case (op_q)
							6'd0: h_q <= mres;
							6'd1: t_q[0] <= mres;
							6'd2: t_q[1] <= mres;
							6'd3: t_q[2] <= mres;
							6'd4: t2_q <= mres;
							6'd5: t2_q <= bpp_pkg::sat_add(t2_q, mres, 1'b0);
							6'd6: t2_q <= bpp_pkg::sat_add(t2_q, mres, 1'b0);
							6'd7, 6'd9, 6'd11, 6'd16, 6'd18, 6'd20: acc_q <= mres;
							6'd8: vp_q[0] <= bpp_pkg::sat_add(vel_q[0],
								bpp_pkg::sat_add(acc_q, mres, 1'b1), 1'b0);
							6'd10: vp_q[1] <= bpp_pkg::sat_add(vel_q[1],
								bpp_pkg::sat_add(acc_q, mres, 1'b1), 1'b0);
							6'd12: vp_q[2] <= bpp_pkg::sat_add(vel_q[2],
								bpp_pkg::sat_add(acc_q, mres, 1'b1), 1'b0);
							6'd13: s_q[0] <= mres;
							6'd14: s_q[1] <= mres;
							6'd15: s_q[2] <= mres;
							6'd17: vn_q[0] <= bpp_pkg::sat_add(vel_q[0],
								bpp_pkg::sat_add(acc_q, mres, 1'b1), 1'b0);
							6'd19: vn_q[1] <= bpp_pkg::sat_add(vel_q[1],
								bpp_pkg::sat_add(acc_q, mres, 1'b1), 1'b0);
							6'd21: vn_q[2] <= bpp_pkg::sat_add(vel_q[2],
								bpp_pkg::sat_add(acc_q, mres, 1'b1), 1'b0);
							6'd22: pos_q[0] <= bpp_pkg::sat_add(pos_q[0], mres, 1'b0);
							6'd23: pos_q[1] <= bpp_pkg::sat_add(pos_q[1], mres, 1'b0);
							6'd24: pos_q[2] <= bpp_pkg::sat_add(pos_q[2], mres, 1'b0);
							default: ;
						endcase
						if (op_q == 6'd12) begin
							state_q <= ST_DIV;
						end else if (op_q == 6'd24) begin
							for (int i = 0; i < 3; i++) vel_q[i] <= vn_q[i];
							out_valid <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							op_q <= op_q + 6'd1;
							state_q <= ST_MUL;
						end
					end
				end
				ST_DIV: state_q <= ST_DWT;
				ST_DWT: begin
					if (ddone) begin
						f_q <= quo;
						op_q <= 6'd13;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && mdone && op_q == 6'd24) begin
			out_data.new_pos_x <= pos_q[0];
			out_data.new_pos_y <= pos_q[1];
			out_data.new_pos_z <= bpp_pkg::sat_add(pos_q[2], mres, 1'b0);
			out_data.new_vel_x <= vn_q[0];
			out_data.new_vel_y <= vn_q[1];
			out_data.new_vel_z <= vn_q[2];
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> (state_q == ST_IDLE)) else $error("result not at end");
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> (state_q == ST_IDLE)) else $error("cfg while busy");
endmodule

### tb/boris_particle_pusher_tb.sv
// Self-checking testbench for boris_particle_pusher: directed rows, then random phases
// under several register settings and idle patterns, checked against a fixed-point
// Boris-rotation predictor. Depends on bpp_pkg and the RTL only.
module boris_particle_pusher_tb;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 400;
	localparam int N_PHASES = 10;
	localparam int PHASE_ITEMS = 135;
	localparam int EXP_DEPTH = 4096;

	typedef struct {
		bpp_pkg::in_item_t item;
		bit pinned;
		bpp_pkg::out_item_t want;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	bpp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	bpp_pkg::out_item_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	boris_particle_pusher uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	longint field_b[3], charge_mass, pos[3], vel[3];
	logic [31:0] step_scale;
	bit pause_steps;

	bpp_pkg::out_item_t exp_mem[EXP_DEPTH];
	int exp_wr, exp_rd;
	bit pin_next;
	bpp_pkg::out_item_t pin_value;
	int errors, n_steps, n_loads, n_results, cycles;
	int send_idle_pct, stall_pct;
	row_t rows[$];

	function automatic longint sat48(longint x);
		if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
		if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
		return x;
	endfunction

	function automatic longint mul_shift(longint a, longint b, int sh);
		logic [63:0] ua, ub;
		logic [127:0] p, lim;
		bit neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		p = {64'd0, ua} * {64'd0, ub};
		p = p >> sh;
		lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
		if (p > lim) p = lim;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic void cross_add(input longint v[3], input longint a[3],
			input longint w[3], output longint r[3]);
		r[0] = sat48(v[0] + sat48(mul_shift(a[1], w[2], 24) - mul_shift(a[2], w[1], 24)));
		r[1] = sat48(v[1] + sat48(mul_shift(a[2], w[0], 24) - mul_shift(a[0], w[2], 24)));
		r[2] = sat48(v[2] + sat48(mul_shift(a[0], w[1], 24) - mul_shift(a[1], w[0], 24)));
	endfunction

	// Returns 1 when the transaction produces a new particle state.
	function automatic bit push_particle(input bpp_pkg::in_item_t it,
			output bpp_pkg::out_item_t res);
		logic [63:0] prod, den;
		longint dt, h, t2, f, sum;
		longint t[3], s[3], vp[3], vn[3];
		res = '0;
		if (it.operation) begin
			pos[0] = it.load_pos_x; pos[1] = it.load_pos_y; pos[2] = it.load_pos_z;
			vel[0] = it.load_vel_x; vel[1] = it.load_vel_y; vel[2] = it.load_vel_z;
			return 0;
		end
		if (pause_steps) return 0;
		prod = 64'(it.time_step) * 64'(step_scale);
		dt = longint'(prod >> 16);
		h = mul_shift(charge_mass, dt, 17);
		for (int i = 0; i < 3; i++) t[i] = mul_shift(field_b[i], h, 16);
		t2 = sat48(sat48(mul_shift(t[0], t[0], 24) + mul_shift(t[1], t[1], 24))
			+ mul_shift(t[2], t[2], 24));
		cross_add(vel, vel, t, vp);
		den = (64'd1 << 24) + 64'(t2);
		f = longint'((64'd1 << 49) / den);
		for (int i = 0; i < 3; i++) s[i] = mul_shift(t[i], f, 24);
		cross_add(vel, vp, s, vn);
		for (int i = 0; i < 3; i++) begin
			sum = vel[i] + vn[i];
			pos[i] = sat48(pos[i] + mul_shift(sum, dt, 25));
			vel[i] = vn[i];
		end
		res.new_pos_x = pos[0][47:0]; res.new_pos_y = pos[1][47:0];
		res.new_pos_z = pos[2][47:0];
		res.new_vel_x = vel[0][47:0]; res.new_vel_y = vel[1][47:0];
		res.new_vel_z = vel[2][47:0];
		return 1;
	endfunction

	always @(posedge clk) begin
		bpp_pkg::out_item_t r;
		if (arst_n && in_valid && !in_stall) begin
			if (in_data.operation) n_loads++;
			else n_steps++;
			if (push_particle(in_data, r)) begin
				exp_mem[exp_wr % EXP_DEPTH] = pin_next ? pin_value : r;
				exp_wr++;
			end
		end
	end

	always @(posedge clk) begin
		bpp_pkg::out_item_t e;
		logic [47:0] got[6], want[6];
		string names[6];
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected transaction on output: %h", $time, out_data);
				errors++;
			end else begin
				e = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				names = '{"new_pos_x", "new_pos_y", "new_pos_z",
					"new_vel_x", "new_vel_y", "new_vel_z"};
				got = '{out_data.new_pos_x, out_data.new_pos_y, out_data.new_pos_z,
					out_data.new_vel_x, out_data.new_vel_y, out_data.new_vel_z};
				want = '{e.new_pos_x, e.new_pos_y, e.new_pos_z,
					e.new_vel_x, e.new_vel_y, e.new_vel_z};
				for (int i = 0; i < 6; i++)
					if (got[i] !== want[i]) begin
						$display("%0t: %s expected %h, got %h", $time, names[i],
							want[i], got[i]);
						errors++;
					end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bpp_pkg::in_item_t make_item(bit op, logic [31:0] ts, longint px,
			longint py, longint pz, longint vx, longint vy, longint vz);
		bpp_pkg::in_item_t it;
		it.operation = op; it.time_step = ts;
		it.load_pos_x = px[47:0]; it.load_pos_y = py[47:0]; it.load_pos_z = pz[47:0];
		it.load_vel_x = vx[47:0]; it.load_vel_y = vy[47:0]; it.load_vel_z = vz[47:0];
		return it;
	endfunction

	function automatic longint rand_coord();
		logic [47:0] raw;
		raw = 48'({$urandom, $urandom});
		if ($urandom_range(99) < 70)
			return longint'($signed(raw[31:0])) >>> $urandom_range(0, 4);
		return longint'($signed(raw));
	endfunction

	function automatic bpp_pkg::in_item_t random_item();
		logic [31:0] ts;
		ts = ($urandom_range(99) < 70) ? $urandom_range(0, 131072) : $urandom;
		return make_item($urandom_range(99) < 20, ts, rand_coord(), rand_coord(),
			rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endfunction

	task automatic send(input bpp_pkg::in_item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
		repeat (gap) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input bpp_pkg::reg_idx_t idx, input logic [31:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			bpp_pkg::REG_FIELD_X: field_b[0] = longint'($signed(value));
			bpp_pkg::REG_FIELD_Y: field_b[1] = longint'($signed(value));
			bpp_pkg::REG_FIELD_Z: field_b[2] = longint'($signed(value));
			bpp_pkg::REG_CHARGE_MASS: charge_mass = longint'($signed(value));
			bpp_pkg::REG_TIME_SCALE: step_scale = value;
			bpp_pkg::REG_PAUSED: pause_steps = value[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (exp_wr != exp_rd) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_field();
		return 32'(longint'($signed($urandom)) >>> $urandom_range(12, 31));
	endfunction

	initial begin
		localparam longint ONE = 64'sd16777216;
		localparam longint PMAX = 64'sh7FFF_FFFF_FFFF;
		localparam longint PMIN = -64'sh8000_0000_0000;
		bpp_pkg::out_item_t z, a, b, c;
		field_b = '{0, 0, 0};
		charge_mass = 65536;
		step_scale = 32'd16777216;
		pause_steps = 0;
		pos = '{0, 0, 0};
		vel = '{0, 0, 0};
		send_idle_pct = 0;
		stall_pct = 0;
		z = '0;
		a = '0;
		a.new_pos_x = ONE[47:0];
		a.new_vel_x = ONE[47:0];
		b = {6{PMAX[47:0]}};
		c = {6{PMIN[47:0]}};
		rows = '{
			'{make_item(0, 32'd65536, 0, 0, 0, 0, 0, 0), 1, z},
			'{make_item(1, 32'hFFFF_FFFF, 0, 0, 0, ONE, 0, 0), 0, z},
			'{make_item(0, 32'd65536, 0, 0, 0, 0, 0, 0), 1, a},
			'{make_item(1, 32'd0, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX), 0, z},
			'{make_item(0, 32'd65536, 0, 0, 0, 0, 0, 0), 1, b},
			'{make_item(1, 32'd0, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN), 0, z},
			'{make_item(0, 32'd65536, -1, -1, -1, -1, -1, -1), 1, c},
			'{make_item(0, 32'd0, 0, 0, 0, 0, 0, 0), 0, z},
			'{make_item(0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 0, z},
			'{make_item(1, 32'd1, ONE, -ONE, 3 * ONE, -2 * ONE, ONE / 2, ONE), 0, z},
			'{make_item(0, 32'd1, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN), 0, z},
			'{make_item(0, 32'd65536, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX), 0, z}
		};

		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (rows[i]) begin
			pin_next = rows[i].pinned;
			pin_value = rows[i].want;
			send(rows[i].item);
		end
		pin_next = 0;
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 61; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 61; end
				default: begin send_idle_pct = 9; stall_pct = 9; end
			endcase
			case (p)
				1: begin
					write_reg(bpp_pkg::REG_FIELD_X, 32'h7FFF_FFFF);
					write_reg(bpp_pkg::REG_FIELD_Y, 32'h7FFF_FFFF);
					write_reg(bpp_pkg::REG_FIELD_Z, 32'h8000_0000);
					write_reg(bpp_pkg::REG_CHARGE_MASS, 32'h7FFF_FFFF);
					write_reg(bpp_pkg::REG_TIME_SCALE, 32'hFFFF_FFFF);
					write_reg(bpp_pkg::REG_PAUSED, 32'd0);
				end
				2: begin
					write_reg(bpp_pkg::REG_FIELD_X, 32'h8000_0000);
					write_reg(bpp_pkg::REG_FIELD_Y, 32'h8000_0000);
					write_reg(bpp_pkg::REG_FIELD_Z, 32'h7FFF_FFFF);
					write_reg(bpp_pkg::REG_CHARGE_MASS, 32'h8000_0000);
					write_reg(bpp_pkg::REG_TIME_SCALE, 32'd0);
				end
				3: write_reg(bpp_pkg::REG_PAUSED, 32'd1);
				default: begin
					write_reg(bpp_pkg::REG_FIELD_X, rand_field());
					write_reg(bpp_pkg::REG_FIELD_Y, rand_field());
					write_reg(bpp_pkg::REG_FIELD_Z, rand_field());
					write_reg(bpp_pkg::REG_CHARGE_MASS, rand_field());
					write_reg(bpp_pkg::REG_TIME_SCALE, $urandom >> $urandom_range(0, 8));
					write_reg(bpp_pkg::REG_PAUSED, 32'd0);
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) send(random_item());
			drain();
		end

		$display("Covered %0d step and %0d load transactions, %0d results checked,",
			n_steps, n_loads, n_results);
		$display("over %0d register settings and four idle patterns.", N_PHASES + 1);
		if (errors == 0 && exp_wr == exp_rd)
			$display("All tests passed");
		else begin
			if (exp_wr != exp_rd)
				$display("%0t: %0d expected results never arrived", $time,
					exp_wr - exp_rd);
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
